// ----- hdl/csft_pkg.sv -----
package csft_pkg;

  // Request codes
  localparam logic [1:0] REQ_ACC = 2'd0;
  localparam logic [1:0] REQ_FIN = 2'd1;
  localparam logic [1:0] REQ_CLS = 2'd2;

  // Frame and histogram sizing
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned SUM_W   = 28;
  localparam int unsigned SQ_W    = 36;
  localparam int unsigned PROD_W  = 58;
  localparam int unsigned MB_W    = 28;
  localparam logic [CNT_W-1:0] MAX_PIXELS = 21'd1048576;

  // floor(x/10) for x below 2^24 as (x * DIV10_RECIP) >> 30
  localparam logic [26:0] DIV10_RECIP = 27'd107374183;

  // Iterative divider sizing
  localparam int unsigned DIV_NW = 74;
  localparam int unsigned DIV_DW = 42;
  localparam int unsigned DIV_QW = 32;
  localparam int unsigned DIV_CW = 7;

  // Iterative square root sizing
  localparam int unsigned SQ_XW = 32;
  localparam int unsigned SQ_RW = 16;
  localparam int unsigned SQ_CW = 5;

  localparam logic [15:0] THR_MIN  = 16'd256;
  localparam logic [15:0] K_RESET  = 16'd768;
  localparam logic [7:0]  PIX_ON   = 8'd255;

  typedef enum logic [1:0] {
    EMIT_IN,
    EMIT_ACC,
    EMIT_FIN
  } emit_src_e;

  typedef enum logic [1:0] {
    MUL_SQ_CNT,
    MUL_SUM_SUM,
    MUL_CNT_CNT
  } mul_sel_e;

  typedef struct packed {
    logic      load;
    logic      acc_wr;
    logic      rd_walk;
    logic      walk_acc;
    logic      clr_step;
    logic      fin_init;
    logic      set_empty;
    logic      mul_start;
    mul_sel_e  mul_sel;
    logic      div_start;
    logic      div_var;
    logic      cap_mean;
    logic      sigma_zero;
    logic      sqrt_start;
    logic      cap_sigma;
    logic      tmul;
    logic      set_thr;
    logic      emit;
    emit_src_e emit_src;
  } cmd_t;

  typedef struct packed {
    logic bin_last;
    logic empty;
    logic cnt_le1;
    logic mul_idle;
    logic div_busy;
    logic sqrt_busy;
  } sts_t;

endpackage

// ----- hdl/csft_div.sv -----
module csft_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [csft_pkg::DIV_NW-1:0]       dividend_i,
  input  logic [csft_pkg::DIV_DW-1:0]       divisor_i,
  output logic [csft_pkg::DIV_QW-1:0]       quot_o,
  output logic                              busy_o
);

  logic [csft_pkg::DIV_NW-1:0] num_q;
  logic [csft_pkg::DIV_DW-1:0] den_q;
  logic [csft_pkg::DIV_DW-1:0] rem_q;
  logic [csft_pkg::DIV_QW-1:0] quo_q;
  logic [csft_pkg::DIV_CW-1:0] cnt_q;
  logic [csft_pkg::DIV_DW:0]   rem_sh;
  logic [csft_pkg::DIV_DW:0]   rem_nx;
  logic                        q_bit;

  // Shift in one dividend bit and try a subtract
  always_comb begin
    rem_sh = {rem_q, num_q[csft_pkg::DIV_NW-1]};
    q_bit  = (rem_sh >= {1'b0, den_q});
    rem_nx = q_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= csft_pkg::DIV_CW'(csft_pkg::DIV_NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[csft_pkg::DIV_NW-2:0], 1'b0};
      rem_q <= rem_nx[csft_pkg::DIV_DW-1:0];
      quo_q <= {quo_q[csft_pkg::DIV_QW-2:0], q_bit};
    end
  end

  assign quot_o = quo_q;
  assign busy_o = (cnt_q != '0);

endmodule

// ----- hdl/csft_isqrt.sv -----
module csft_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [csft_pkg::SQ_XW-1:0]  x_i,
  output logic [csft_pkg::SQ_RW-1:0]  root_o,
  output logic                        busy_o
);

  logic [csft_pkg::SQ_XW-1:0] x_q;
  logic [csft_pkg::SQ_XW-1:0] res_q;
  logic [csft_pkg::SQ_XW-1:0] bit_q;
  logic [csft_pkg::SQ_CW-1:0] cnt_q;
  logic [csft_pkg::SQ_XW-1:0] trial;

  assign trial = res_q + bit_q;

  // Iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= csft_pkg::SQ_CW'(csft_pkg::SQ_RW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // One root bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= {2'b01, {(csft_pkg::SQ_XW-2){1'b0}}};
    end else if (cnt_q != '0) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = res_q[csft_pkg::SQ_RW-1:0];
  assign busy_o = (cnt_q != '0);

endmodule

// ----- hdl/csft_dp.sv -----
module csft_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csft_pkg::cmd_t      cmd_i,
  output csft_pkg::sts_t      sts_o,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          image_pixel_i,
  input  logic [7:0]          background_pixel_i,
  input  logic                k_we_i,
  input  logic signed [15:0]  k_i,
  output logic                done_o,
  output logic [7:0]          residual_o,
  output logic [7:0]          binary_pixel_o,
  output logic [15:0]         threshold_q8_o,
  output logic [7:0]          cutoff_value_o,
  output logic [15:0]         mean_q8_o,
  output logic [15:0]         sigma_q8_o
);

  logic [csft_pkg::CNT_W-1:0]  hist [256];
  logic [csft_pkg::CNT_W-1:0]  rdata_q;
  logic [7:0]                  rd_addr;
  logic [7:0]                  wr_addr;
  logic [csft_pkg::CNT_W-1:0]  wr_data;
  logic                        wr_en;

  logic [7:0]                  res_in;
  logic [7:0]                  res_q;
  logic [csft_pkg::CNT_W-1:0]  total_q;
  logic signed [15:0]          k_q;
  logic [15:0]                 thr_q;
  logic [7:0]                  cut_q;
  logic [15:0]                 mean_q;
  logic [15:0]                 sigma_q;

  logic [7:0]                  bin_q;
  logic [15:0]                 vv_q;
  logic [16:0]                 vv_nx;
  logic [csft_pkg::CNT_W-1:0]  idx_q;
  logic [23:0]                 nine_n;
  logic [50:0]                 idx_prod;
  logic [csft_pkg::CNT_W-1:0]  cnt_q;
  logic [csft_pkg::SUM_W-1:0]  sum_q;
  logic [csft_pkg::SQ_W-1:0]   sq_q;
  logic                        found_q;
  logic                        empty_q;
  logic [csft_pkg::CNT_W-1:0]  cnt_nx;
  logic [28:0]                 vh;
  logic [36:0]                 vvh;

  logic [csft_pkg::PROD_W-1:0] ma_q;
  logic [csft_pkg::MB_W-1:0]   mb_q;
  logic [csft_pkg::PROD_W-1:0] mp_q;
  logic [csft_pkg::PROD_W-1:0] a_q;
  logic [csft_pkg::PROD_W-1:0] b_q;
  logic [csft_pkg::PROD_W-1:0] d_w;

  logic [csft_pkg::DIV_NW-1:0] div_num;
  logic [csft_pkg::DIV_DW-1:0] div_den;
  logic [csft_pkg::DIV_QW-1:0] div_quo;
  logic                        div_busy;
  logic [csft_pkg::SQ_RW-1:0]  sq_root;
  logic                        sq_busy;

  logic signed [32:0]          tprod_q;
  logic signed [34:0]          tsum;
  logic [15:0]                 thr_nx;

  logic                        done_q;
  logic [7:0]                  res_out_q;
  logic [7:0]                  bin_out_q;

  assign res_in = (image_pixel_i > background_pixel_i) ?
                  (image_pixel_i - background_pixel_i) : 8'd0;

  // Histogram port selection
  always_comb begin
    rd_addr = cmd_i.rd_walk ? bin_q : res_in;
    wr_en   = 1'b0;
    wr_addr = bin_q;
    wr_data = '0;
    if (cmd_i.acc_wr && (total_q < csft_pkg::MAX_PIXELS)) begin
      wr_en   = 1'b1;
      wr_addr = res_q;
      wr_data = rdata_q + 1'b1;
    end else if (cmd_i.walk_acc || cmd_i.clr_step) begin
      wr_en = 1'b1;
    end
  end

  // Histogram memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist[wr_addr] <= wr_data;
    end
    rdata_q <= hist[rd_addr];
  end

  // Walk arithmetic
  always_comb begin
    nine_n   = {total_q, 3'b000} + {3'b000, total_q};
    idx_prod = 51'(nine_n) * 51'(csft_pkg::DIV10_RECIP);
    cnt_nx   = cnt_q + rdata_q;
    vh       = {21'd0, bin_q} * {8'd0, rdata_q};
    vvh      = {21'd0, vv_q} * {16'd0, rdata_q};
    vv_nx    = {1'b0, vv_q} + {8'd0, bin_q, 1'b0} + 17'd1;
    d_w      = (a_q > b_q) ? (a_q - b_q) : '0;
  end

  // Divider operands
  always_comb begin
    if (cmd_i.div_var) begin
      div_num = {d_w, 16'd0};
      div_den = mp_q[csft_pkg::DIV_DW-1:0];
    end else begin
      div_num = {38'd0, sum_q, 8'd0};
      div_den = {21'd0, cnt_q};
    end
  end

  csft_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .quot_o     (div_quo),
    .busy_o     (div_busy)
  );

  csft_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .x_i     (div_quo),
    .root_o  (sq_root),
    .busy_o  (sq_busy)
  );

  // Threshold from mean and scaled sigma
  always_comb begin
    tsum = $signed({11'd0, mean_q, 8'd0}) + {{2{tprod_q[32]}}, tprod_q};
    if (tsum < 35'sd65536) begin
      thr_nx = csft_pkg::THR_MIN;
    end else if (tsum[34:8] > 27'd65535) begin
      thr_nx = 16'hFFFF;
    end else begin
      thr_nx = tsum[23:8];
    end
  end

  // Frame state, statistics and sequencing counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      k_q     <= csft_pkg::K_RESET;
      thr_q   <= csft_pkg::THR_MIN;
      cut_q   <= '0;
      mean_q  <= '0;
      sigma_q <= '0;
      bin_q   <= '0;
      vv_q    <= '0;
      found_q <= 1'b0;
      empty_q <= 1'b0;
      mb_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (k_we_i) begin
        k_q <= k_i;
      end
      if (cmd_i.acc_wr && (total_q < csft_pkg::MAX_PIXELS)) begin
        total_q <= total_q + 1'b1;
      end
      // Open a finish pass
      if (cmd_i.fin_init) begin
        total_q <= '0;
        empty_q <= (total_q == '0);
        found_q <= 1'b0;
        bin_q   <= '0;
        vv_q    <= '0;
      end
      if (cmd_i.clr_step) begin
        bin_q <= bin_q + 1'b1;
      end
      // Walk one bin: stop counting once the cutoff is passed
      if (cmd_i.walk_acc) begin
        bin_q <= bin_q + 1'b1;
        vv_q  <= vv_nx[15:0];
        if (!found_q && (cnt_nx > idx_q)) begin
          found_q <= 1'b1;
          cut_q   <= bin_q;
        end
      end
      if (cmd_i.set_empty) begin
        thr_q   <= csft_pkg::THR_MIN;
        cut_q   <= '0;
        mean_q  <= '0;
        sigma_q <= '0;
      end
      if (cmd_i.cap_mean) begin
        mean_q <= div_quo[15:0];
      end
      if (cmd_i.sigma_zero) begin
        sigma_q <= '0;
      end
      if (cmd_i.cap_sigma) begin
        sigma_q <= sq_root;
      end
      if (cmd_i.set_thr) begin
        thr_q <= thr_nx;
      end
      // Shift-add multiplier control
      if (cmd_i.mul_start) begin
        unique case (cmd_i.mul_sel)
          csft_pkg::MUL_SQ_CNT:  mb_q <= {7'd0, cnt_q};
          csft_pkg::MUL_SUM_SUM: mb_q <= sum_q;
          csft_pkg::MUL_CNT_CNT: mb_q <= {7'd0, cnt_q};
          default:               mb_q <= '0;
        endcase
      end else if (mb_q != '0) begin
        mb_q <= mb_q >> 1;
      end
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= res_in;
    end
    if (cmd_i.fin_init) begin
      idx_q <= idx_prod[50:30];
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
    end
    if (cmd_i.walk_acc && !found_q) begin
      cnt_q <= cnt_nx;
      sum_q <= sum_q + vh[csft_pkg::SUM_W-1:0];
      sq_q  <= sq_q + vvh[csft_pkg::SQ_W-1:0];
    end
    // Start a product; a sum*sum or cnt*cnt start saves the previous product on the same edge
    if (cmd_i.mul_start) begin
      mp_q <= '0;
      unique case (cmd_i.mul_sel)
        csft_pkg::MUL_SQ_CNT:  ma_q <= csft_pkg::PROD_W'(sq_q);
        csft_pkg::MUL_SUM_SUM: ma_q <= csft_pkg::PROD_W'(sum_q);
        csft_pkg::MUL_CNT_CNT: ma_q <= csft_pkg::PROD_W'(cnt_q);
        default:               ma_q <= '0;
      endcase
      if (cmd_i.mul_sel == csft_pkg::MUL_SUM_SUM) begin
        a_q <= mp_q;
      end
      if (cmd_i.mul_sel == csft_pkg::MUL_CNT_CNT) begin
        b_q <= mp_q;
      end
    end else if (mb_q != '0) begin
      if (mb_q[0]) begin
        mp_q <= mp_q + ma_q;
      end
      ma_q <= {ma_q[csft_pkg::PROD_W-2:0], 1'b0};
    end
    if (cmd_i.tmul) begin
      tprod_q <= k_q * $signed({1'b0, sigma_q});
    end
    // Result payload
    if (cmd_i.emit) begin
      unique case (cmd_i.emit_src)
        csft_pkg::EMIT_IN: begin
          res_out_q <= res_in;
          bin_out_q <= ((req_type_i == csft_pkg::REQ_CLS) && ({res_in, 8'd0} > thr_q)) ?
                       csft_pkg::PIX_ON : 8'd0;
        end
        csft_pkg::EMIT_ACC: begin
          res_out_q <= res_q;
          bin_out_q <= 8'd0;
        end
        default: begin
          res_out_q <= 8'd0;
          bin_out_q <= 8'd0;
        end
      endcase
    end
  end

  always_comb begin
    sts_o.bin_last  = (bin_q == 8'd255);
    sts_o.empty     = empty_q;
    sts_o.cnt_le1   = (cnt_q <= 21'd1);
    sts_o.mul_idle  = (mb_q == '0);
    sts_o.div_busy  = div_busy;
    sts_o.sqrt_busy = sq_busy;
  end

  assign done_o         = done_q;
  assign residual_o     = res_out_q;
  assign binary_pixel_o = bin_out_q;
  assign threshold_q8_o = thr_q;
  assign cutoff_value_o = cut_q;
  assign mean_q8_o      = mean_q;
  assign sigma_q8_o     = sigma_q;

`ifndef SYNTHESIS
  a_thr_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_q >= csft_pkg::THR_MIN)
    else $error("threshold below 1.0");

  a_total_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= csft_pkg::MAX_PIXELS)
    else $error("pixel count beyond frame limit");

  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((mb_q != '0) && (div_busy || sq_busy)))
    else $error("multiplier overlaps divider or root unit");

  a_walk_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.walk_acc && (bin_q == 8'd255)) |=> (bin_q == 8'd0))
    else $error("bin counter did not wrap after last bin");
`endif

endmodule

// ----- hdl/csft_ctrl.sv -----
module csft_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [1:0]      req_type_i,
  input  csft_pkg::sts_t  sts_i,
  output csft_pkg::cmd_t  cmd_o,
  output logic            busy
);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_ACC     = 5'd2;
  localparam logic [4:0] S_FIN     = 5'd3;
  localparam logic [4:0] S_WRD     = 5'd4;
  localparam logic [4:0] S_WACC    = 5'd5;
  localparam logic [4:0] S_EMPTY   = 5'd6;
  localparam logic [4:0] S_MEAN    = 5'd7;
  localparam logic [4:0] S_MEAN_W  = 5'd8;
  localparam logic [4:0] S_MUL_A   = 5'd9;
  localparam logic [4:0] S_MUL_A_W = 5'd10;
  localparam logic [4:0] S_MUL_B   = 5'd11;
  localparam logic [4:0] S_MUL_B_W = 5'd12;
  localparam logic [4:0] S_MUL_C   = 5'd13;
  localparam logic [4:0] S_MUL_C_W = 5'd14;
  localparam logic [4:0] S_VAR     = 5'd15;
  localparam logic [4:0] S_VAR_W   = 5'd16;
  localparam logic [4:0] S_SQRT    = 5'd17;
  localparam logic [4:0] S_SQRT_W  = 5'd18;
  localparam logic [4:0] S_TMUL    = 5'd19;
  localparam logic [4:0] S_THR     = 5'd20;

  logic [4:0] state_q;
  logic [4:0] state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.bin_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          priority if (req_type_i == csft_pkg::REQ_ACC) begin
            state_d = S_ACC;
          end else if (req_type_i == csft_pkg::REQ_FIN) begin
            state_d = S_FIN;
          end else begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_src = csft_pkg::EMIT_IN;
          end
        end
      end
      S_ACC: begin
        cmd_o.acc_wr   = 1'b1;
        cmd_o.emit     = 1'b1;
        cmd_o.emit_src = csft_pkg::EMIT_ACC;
        state_d        = S_IDLE;
      end
      S_FIN: begin
        cmd_o.fin_init = 1'b1;
        state_d        = S_WRD;
      end
      S_WRD: begin
        cmd_o.rd_walk = 1'b1;
        state_d       = S_WACC;
      end
      S_WACC: begin
        cmd_o.walk_acc = 1'b1;
        if (!sts_i.bin_last) begin
          state_d = S_WRD;
        end else if (sts_i.empty) begin
          state_d = S_EMPTY;
        end else begin
          state_d = S_MEAN;
        end
      end
      S_EMPTY: begin
        cmd_o.set_empty = 1'b1;
        cmd_o.emit      = 1'b1;
        cmd_o.emit_src  = csft_pkg::EMIT_FIN;
        state_d         = S_IDLE;
      end
      S_MEAN: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_MEAN_W;
      end
      S_MEAN_W: begin
        if (!sts_i.div_busy) begin
          cmd_o.cap_mean = 1'b1;
          if (sts_i.cnt_le1) begin
            cmd_o.sigma_zero = 1'b1;
            state_d          = S_TMUL;
          end else begin
            state_d = S_MUL_A;
          end
        end
      end
      S_MUL_A: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = csft_pkg::MUL_SQ_CNT;
        state_d         = S_MUL_A_W;
      end
      S_MUL_A_W: begin
        if (sts_i.mul_idle) begin
          state_d = S_MUL_B;
        end
      end
      S_MUL_B: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = csft_pkg::MUL_SUM_SUM;
        state_d         = S_MUL_B_W;
      end
      S_MUL_B_W: begin
        if (sts_i.mul_idle) begin
          state_d = S_MUL_C;
        end
      end
      S_MUL_C: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = csft_pkg::MUL_CNT_CNT;
        state_d         = S_MUL_C_W;
      end
      S_MUL_C_W: begin
        if (sts_i.mul_idle) begin
          state_d = S_VAR;
        end
      end
      S_VAR: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_var   = 1'b1;
        state_d         = S_VAR_W;
      end
      S_VAR_W: begin
        if (!sts_i.div_busy) begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (!sts_i.sqrt_busy) begin
          cmd_o.cap_sigma = 1'b1;
          state_d         = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd_o.tmul = 1'b1;
        state_d    = S_THR;
      end
      S_THR: begin
        cmd_o.set_thr  = 1'b1;
        cmd_o.emit     = 1'b1;
        cmd_o.emit_src = csft_pkg::EMIT_FIN;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ----- hdl/clipped_sigma_frame_threshold_unit.sv -----
// Clipped-sigma frame threshold unit.
// Requests enter on start/busy: a request transfers at a clock edge with
// start high and busy low. req_type selects accumulate, finish or classify.
// Each request yields one result, shown for exactly one cycle with done_o
// high; the receiver cannot stall, so results must be taken as they come.
// Classify (and the unused code): done_o rises the cycle after the
// transfer and busy stays low, so one request fits every cycle.
// Accumulate: busy is high for one cycle while the histogram bin is read,
// incremented and written back through its one write port.
// Finish walks and clears all 256 bins (read and write share the histogram
// memory); a non-empty frame then divides for the mean and, with more than
// one pixel counted, runs three shift-add products, a division and a root.
// sigma_multiplier_q8_we_i writes the sigma multiplier; the user asserts it
// only while idle; the unit does not enforce it. After reset it clears its
// histogram with busy high; the threshold starts at 1.0, multiplier at 3.0.
module clipped_sigma_frame_threshold_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         image_pixel_i,
  input  logic [7:0]         background_pixel_i,
  input  logic               sigma_multiplier_q8_we_i,
  input  logic signed [15:0] sigma_multiplier_q8_i,
  output logic               done_o,
  output logic [7:0]         residual_o,
  output logic [7:0]         binary_pixel_o,
  output logic [15:0]        threshold_q8_o,
  output logic [7:0]         cutoff_value_o,
  output logic [15:0]        mean_q8_o,
  output logic [15:0]        sigma_q8_o
);

  csft_pkg::cmd_t cmd;
  csft_pkg::sts_t sts;

  csft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  csft_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .req_type_i         (req_type_i),
    .image_pixel_i      (image_pixel_i),
    .background_pixel_i (background_pixel_i),
    .k_we_i             (sigma_multiplier_q8_we_i),
    .k_i                (sigma_multiplier_q8_i),
    .done_o             (done_o),
    .residual_o         (residual_o),
    .binary_pixel_o     (binary_pixel_o),
    .threshold_q8_o     (threshold_q8_o),
    .cutoff_value_o     (cutoff_value_o),
    .mean_q8_o          (mean_q8_o),
    .sigma_q8_o         (sigma_q8_o)
  );

endmodule
